// ===== rtl/pip_pkg.sv =====
// Shared types and constants of the point-in-polygon classifier.
// No dependencies; used by the front end, the back end and the top level.

package pip_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_QUERY_X = 2'd0;
  localparam logic [1:0] REG_QUERY_Y = 2'd1;

  // result codes
  typedef enum logic [1:0] {
    POS_INSIDE   = 2'd0,
    POS_OUTSIDE  = 2'd1,
    POS_BOUNDARY = 2'd2
  } pip_pos_e;

  // per-edge classification, computed by the front end
  typedef struct packed {
    logic in_box;      // query point inside the edge's bounding box
    logic horiz;       // start y equals end y
    logic start_ray;   // start vertex lies on the ray
    logic start_up;    // start vertex is the upper endpoint
    logic end_ray;     // end vertex lies on the ray
    logic end_up;      // end vertex is the upper endpoint
    logic straddle;    // edge strictly spans the query y
    logic final_edge;  // last edge of the polygon
  } pip_flags_t;

  localparam int unsigned FlagBits = $bits(pip_flags_t);

endpackage

// ===== rtl/pip_fifo.sv =====
// Small register-based queue with combinational head read.
// No dependencies; a write while full is allowed only together with a read.

module pip_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntBits'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/pip_front.sv =====
// Front end: holds the query point and classifies each incoming edge.
// Depends on pip_pkg for register indexes and the classification struct.

module pip_front #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [CoordBits-1:0]        cfg_data_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic                        final_edge_i,
  output pip_pkg::pip_flags_t         flags_o,
  output logic signed [CoordBits:0]   dx_o,
  output logic signed [CoordBits:0]   dy_o,
  output logic signed [CoordBits:0]   qxs_o,
  output logic signed [CoordBits:0]   qys_o
);

  logic signed [CoordBits-1:0] qx_q, qx_d;
  logic signed [CoordBits-1:0] qy_q, qy_d;
  logic in_x, in_y;

  // query point registers
  always_comb begin
    qx_d = qx_q;
    qy_d = qy_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pip_pkg::REG_QUERY_X: qx_d = cfg_data_i;
        pip_pkg::REG_QUERY_Y: qy_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
    end else begin
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  // differences, one bit wider than the coordinates
  assign dx_o  = {end_x_i[CoordBits-1], end_x_i} - {start_x_i[CoordBits-1], start_x_i};
  assign dy_o  = {end_y_i[CoordBits-1], end_y_i} - {start_y_i[CoordBits-1], start_y_i};
  assign qxs_o = {qx_q[CoordBits-1], qx_q} - {start_x_i[CoordBits-1], start_x_i};
  assign qys_o = {qy_q[CoordBits-1], qy_q} - {start_y_i[CoordBits-1], start_y_i};

  // bounding box test
  assign in_x = (start_x_i <= qx_q && qx_q <= end_x_i) ||
                (end_x_i <= qx_q && qx_q <= start_x_i);
  assign in_y = (start_y_i <= qy_q && qy_q <= end_y_i) ||
                (end_y_i <= qy_q && qy_q <= start_y_i);

  // vertex and straddle classification
  always_comb begin
    flags_o.in_box     = in_x && in_y;
    flags_o.horiz      = (start_y_i == end_y_i);
    flags_o.start_ray  = (start_y_i == qy_q) && (start_x_i <= qx_q);
    flags_o.start_up   = (start_y_i > end_y_i);
    flags_o.end_ray    = (end_y_i == qy_q) && (end_x_i <= qx_q);
    flags_o.end_up     = (end_y_i > start_y_i);
    flags_o.straddle   = (start_y_i < qy_q && qy_q < end_y_i) ||
                         (end_y_i < qy_q && qy_q < start_y_i);
    flags_o.final_edge = final_edge_i;
  end

endmodule

// ===== rtl/pip_back.sv =====
// Back end: cross-product stage, parity and boundary state, result request.
// Depends on pip_pkg for the classification struct and result codes.

module pip_back #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_pop_o,
  input  pip_pkg::pip_flags_t         flags_i,
  input  logic signed [CoordBits:0]   dx_i,
  input  logic signed [CoordBits:0]   dy_i,
  input  logic signed [CoordBits:0]   qxs_i,
  input  logic signed [CoordBits:0]   qys_i,
  input  logic                        res_room_i,
  output logic                        res_push_o,
  output logic [1:0]                  res_pos_o
);

  localparam int unsigned ProdBits = 2 * (CoordBits + 1);

  logic                       s1_v_q, s1_v_d;
  pip_pkg::pip_flags_t        s1_flags_q;
  logic signed [ProdBits-1:0] p1_q, p2_q;
  logic                       parity_q, parity_d;
  logic                       bnd_q, bnd_d;
  logic                       advance;
  logic                       on_edge, left, toggle;
  logic                       par_new, bnd_new;
  pip_pkg::pip_pos_e          pos;

  // stall only when a result is due and the output queue has no room
  assign advance    = !(s1_v_q && s1_flags_q.final_edge && !res_room_i);
  assign item_pop_o = advance && item_valid_i;
  assign s1_v_d     = advance ? item_valid_i : s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  // the two cross products, registered
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_flags_q <= flags_i;
      p1_q       <= dx_i * qys_i;
      p2_q       <= dy_i * qxs_i;
    end
  end

  // edge test and crossing rule
  always_comb begin
    on_edge = s1_flags_q.in_box && (p1_q == p2_q);
    left    = s1_flags_q.end_up ? (p1_q < p2_q) : (p1_q > p2_q);
    toggle  = 1'b0;
    if (!on_edge && !s1_flags_q.horiz) begin
      if (s1_flags_q.start_ray) begin
        toggle = s1_flags_q.start_up;
      end else if (s1_flags_q.end_ray) begin
        toggle = s1_flags_q.end_up;
      end else if (s1_flags_q.straddle) begin
        toggle = left;
      end
    end
    par_new = parity_q ^ toggle;
    bnd_new = bnd_q | on_edge;
  end

  // state update and result on the final edge
  always_comb begin
    parity_d = parity_q;
    bnd_d    = bnd_q;
    if (s1_v_q && advance) begin
      if (s1_flags_q.final_edge) begin
        parity_d = 1'b0;
        bnd_d    = 1'b0;
      end else begin
        parity_d = par_new;
        bnd_d    = bnd_new;
      end
    end
  end

  always_comb begin
    if (bnd_new) begin
      pos = pip_pkg::POS_BOUNDARY;
    end else if (par_new) begin
      pos = pip_pkg::POS_INSIDE;
    end else begin
      pos = pip_pkg::POS_OUTSIDE;
    end
  end

  assign res_push_o = s1_v_q && s1_flags_q.final_edge && advance;
  assign res_pos_o  = pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      bnd_q    <= 1'b0;
    end else begin
      parity_q <= parity_d;
      bnd_q    <= bnd_d;
    end
  end

endmodule

// ===== rtl/point_in_polygon_test_top.sv =====
// Point-in-polygon classifier: one polygon edge per request, ray cast toward minus x.
// Takes one edge every clock cycle while the classify queue is not full; a final edge
// passes through the classify queue and the registered cross-product stage into the result queue.
// Depends on pip_pkg, pip_fifo, pip_front and pip_back.

module point_in_polygon_test_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         final_edge_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   position_o
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned MidBits  = pip_pkg::FlagBits + 4 * DiffBits;

  pip_pkg::pip_flags_t         f_flags, b_flags;
  logic signed [COORD_BITS:0]  f_dx, f_dy, f_qxs, f_qys;
  logic signed [COORD_BITS:0]  b_dx, b_dy, b_qxs, b_qys;
  logic [MidBits-1:0]          mid_wr, mid_rd;
  logic                        mid_full, mid_empty, mid_pop;
  logic                        res_push, res_full, res_room;
  logic [1:0]                  res_pos;
  logic                        in_accept, out_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !mid_full;
  assign out_accept  = pop && !empty;
  assign full        = mid_full;

  // front end: query registers and edge classification
  pip_front #(
    .CoordBits (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .final_edge_i (final_edge_i),
    .flags_o      (f_flags),
    .dx_o         (f_dx),
    .dy_o         (f_dy),
    .qxs_o        (f_qxs),
    .qys_o        (f_qys)
  );

  // queue between classification and evaluation
  assign mid_wr = {f_flags, f_dx, f_dy, f_qxs, f_qys};

  pip_fifo #(
    .Width (MidBits),
    .Depth (2)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept),
    .wr_data_i (mid_wr),
    .full_o    (mid_full),
    .rd_en_i   (mid_pop),
    .rd_data_o (mid_rd),
    .empty_o   (mid_empty)
  );

  assign {b_flags, b_dx, b_dy, b_qxs, b_qys} = mid_rd;

  // back end: cross products, parity and boundary state
  assign res_room = !res_full || out_accept;

  pip_back #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mid_empty),
    .item_pop_o   (mid_pop),
    .flags_i      (b_flags),
    .dx_i         (b_dx),
    .dy_i         (b_dy),
    .qxs_i        (b_qxs),
    .qys_i        (b_qys),
    .res_room_i   (res_room),
    .res_push_o   (res_push),
    .res_pos_o    (res_pos)
  );

  // result queue
  pip_fifo #(
    .Width (2),
    .Depth (2)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_pos),
    .full_o    (res_full),
    .rd_en_i   (out_accept),
    .rd_data_o (position_o),
    .empty_o   (empty)
  );

endmodule
